// ===== rtl/picm_pkg.sv =====
package picm_pkg;

    localparam int CFG_W  = 32;
    localparam int CPO_W  = 17;
    localparam int TICK_W = 32;
    localparam int CAP_IN_W = 16;
    localparam int DUTY_W = 16;
    localparam int DIV_W  = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [0:0] REG_TIMER_CLOCK_HZ      = 1'b0;
    localparam logic [0:0] REG_COUNTS_PER_OVERFLOW = 1'b1;

    localparam logic [CFG_W-1:0] TIMER_CLOCK_HZ_RESET      = 32'd1000000;
    localparam logic [CPO_W-1:0] COUNTS_PER_OVERFLOW_RESET = 17'd256;

    localparam logic MODE_EDGE     = 1'b0;
    localparam logic MODE_OVERFLOW = 1'b1;

    localparam logic SENSE_RISE = 1'b0;
    localparam logic SENSE_FALL = 1'b1;

    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_FALL  = 2'd1;
    localparam logic [1:0] PHASE_RISE  = 2'd2;

    localparam logic [DIV_CNT_W-1:0] FREQ_STEPS = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DUTY_STEPS = 6'd16;
    localparam logic [DUTY_W-1:0]    DUTY_MAX   = 16'hFFFF;

    typedef struct packed {
        logic                mode;
        logic [CAP_IN_W-1:0] capture_count;
    } in_t;

    typedef struct packed {
        logic              sense_falling;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] period_ticks;
        logic [TICK_W-1:0] frequency_hz;
        logic [DUTY_W-1:0] duty_fraction;
        logic              measurement_valid;
    } out_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic update;
        logic clear_res;
        logic div_freq;
        logic store_freq;
        logic sat_duty;
        logic div_duty;
        logic store_duty;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic period_zero;
        logic high_ge_period;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/picm_div.sv =====
module picm_div
    import picm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     rem_init,
    input  logic [DIV_W-1:0]     num,
    input  logic [DIV_W-1:0]     den,
    input  logic [DIV_CNT_W-1:0] steps,
    output logic                 done,
    output logic [DIV_W-1:0]     quot
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = (trial >= {1'b0, den});

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            num_next  = num;
            quot_next = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_next  = {num_reg[DIV_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/picm_dp.sv =====
module picm_dp
    import picm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 16,
    parameter int OVERFLOW_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  in_t              in_data,
    input  cmd_t             cmd,
    output sts_t             sts,
    output out_t             out_data
);

    localparam int CAP_W  = (COUNTER_WIDTH < CAP_IN_W) ? COUNTER_WIDTH : CAP_IN_W;
    localparam int PROD_W = OVERFLOW_WIDTH + CPO_W;
    localparam int SUM_W  = (PROD_W + 1 > TICK_W + 1) ? PROD_W + 1 : TICK_W + 1;

    logic [CFG_W-1:0]          tch_reg;
    logic [CPO_W-1:0]          cpo_reg;
    logic                      mode_reg;
    logic [CAP_W-1:0]          cap_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [1:0]                phase_reg, phase_next;
    logic [CAP_W-1:0]          start_reg, start_next;
    logic [OVERFLOW_WIDTH-1:0] ovf_reg, ovf_next;
    logic [TICK_W-1:0]         pend_reg, pend_next;
    logic [TICK_W-1:0]         lhigh_reg, lhigh_next;
    logic [TICK_W-1:0]         lper_reg, lper_next;
    logic                      vflag_reg, vflag_next;
    logic [TICK_W-1:0]         freq_reg;
    logic [DUTY_W-1:0]         duty_reg;
    out_t                      out_reg;
    logic [SUM_W-1:0]          sum;
    logic [SUM_W-1:0]          start_ext;
    logic [SUM_W-1:0]          delta;
    logic [TICK_W-1:0]         span;
    logic                      div_start;
    logic [DIV_W-1:0]          div_rem_init;
    logic [DIV_W-1:0]          div_num;
    logic [DIV_CNT_W-1:0]      div_steps;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tch_reg <= TIMER_CLOCK_HZ_RESET;
            cpo_reg <= COUNTS_PER_OVERFLOW_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TIMER_CLOCK_HZ)
            begin
                tch_reg <= cfg_data;
            end
            if (cfg_index == REG_COUNTS_PER_OVERFLOW)
            begin
                cpo_reg <= cfg_data[CPO_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= in_data.mode;
            cap_reg  <= in_data.capture_count[CAP_W-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(ovf_reg) * PROD_W'(cpo_reg);
        end
    end

    // Ticks since the start count; clamps at zero and at the 32-bit maximum.
    assign sum       = SUM_W'(cap_reg) + SUM_W'(prod_reg);
    assign start_ext = SUM_W'(start_reg);
    assign delta     = sum - start_ext;

    always_comb
    begin
        if (sum < start_ext)
        begin
            span = '0;
        end
        else if (|delta[SUM_W-1:TICK_W])
        begin
            span = '1;
        end
        else
        begin
            span = delta[TICK_W-1:0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        lhigh_next = lhigh_reg;
        lper_next  = lper_reg;
        vflag_next = vflag_reg;
        if (cmd.update)
        begin
            if (mode_reg == MODE_OVERFLOW)
            begin
                if (ovf_reg != '1)
                begin
                    ovf_next = ovf_reg + OVERFLOW_WIDTH'(1);
                end
            end
            else
            begin
                unique case (phase_reg)
                    PHASE_FALL:
                    begin
                        pend_next  = span;
                        phase_next = PHASE_RISE;
                    end
                    PHASE_RISE:
                    begin
                        lper_next  = span;
                        lhigh_next = pend_reg;
                        vflag_next = 1'b1;
                        ovf_next   = '0;
                        start_next = cap_reg;
                        phase_next = PHASE_FALL;
                    end
                    default:
                    begin
                        start_next = cap_reg;
                        ovf_next   = '0;
                        phase_next = PHASE_FALL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            start_reg <= '0;
            ovf_reg   <= '0;
            pend_reg  <= '0;
            lhigh_reg <= '0;
            lper_reg  <= '0;
            vflag_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            lhigh_reg <= lhigh_next;
            lper_reg  <= lper_next;
            vflag_reg <= vflag_next;
        end
    end

    // The duty division starts from the high time as remainder, since the
    // high time is below the period whenever it runs.
    assign div_start    = cmd.div_freq | cmd.div_duty;
    assign div_rem_init = cmd.div_duty ? lhigh_reg : '0;
    assign div_num      = cmd.div_duty ? '0 : tch_reg;
    assign div_steps    = cmd.div_duty ? DUTY_STEPS : FREQ_STEPS;

    picm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .den      (lper_reg),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.clear_res)
        begin
            freq_reg <= '0;
            duty_reg <= '0;
        end
        if (cmd.store_freq)
        begin
            freq_reg <= div_quot;
        end
        if (cmd.sat_duty)
        begin
            duty_reg <= DUTY_MAX;
        end
        if (cmd.store_duty)
        begin
            duty_reg <= div_quot[DUTY_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg.sense_falling     <= (phase_reg == PHASE_FALL) ? SENSE_FALL
                                                                   : SENSE_RISE;
            out_reg.high_ticks        <= lhigh_reg;
            out_reg.period_ticks      <= lper_reg;
            out_reg.frequency_hz      <= freq_reg;
            out_reg.duty_fraction     <= duty_reg;
            out_reg.measurement_valid <= vflag_reg;
        end
    end

    assign sts.period_zero    = (lper_reg == '0);
    assign sts.high_ge_period = (lhigh_reg >= lper_reg);
    assign sts.div_done       = div_done;
    assign out_data           = out_reg;

endmodule

// ===== rtl/picm_ctrl.sv =====
module picm_ctrl
    import picm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SPAN  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FREQ  = 3'd4;
    localparam logic [2:0] S_DUTY  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.period_zero)
                begin
                    cmd.clear_res = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.div_freq = 1'b1;
                    state_next   = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (sts.div_done)
                begin
                    cmd.store_freq = 1'b1;
                    if (sts.high_ge_period)
                    begin
                        cmd.sat_duty = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        cmd.div_duty = 1'b1;
                        state_next   = S_DUTY;
                    end
                end
            end
            S_DUTY:
            begin
                if (sts.div_done)
                begin
                    cmd.store_duty = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/pwm_input_capture_meter_unit.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    in_data  (mode, capture_count)
// out       out        out_valid / out_ready  out_data (edge, ticks, frequency, duty, valid)
//
// in_ready stays low from acceptance until the result is loaded into the output
// register, while the 32-step frequency division and the 16-step duty division
// run on one shared bit-serial divider. A zero period skips both divisions, and
// a high time that reaches the period skips the duty division. A finished result
// waits in the output register while the next request is accepted. Reset is
// asynchronous and needs no clearing pass.
module pwm_input_capture_meter_unit
    import picm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 16,
    parameter int OVERFLOW_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data
);

    cmd_t cmd;
    sts_t sts;

    picm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    picm_dp #(
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .OVERFLOW_WIDTH (OVERFLOW_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while the previous one is still in work");

    a_zero_period_results: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.period_ticks == '0)
        |-> (out_data.frequency_hz == '0) && (out_data.duty_fraction == '0))
        else $error("nonzero frequency or duty with a zero period");

    a_period_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.measurement_valid |-> (out_data.period_ticks == '0))
        else $error("period reported before a full period was measured");

endmodule

// ===== test/pwm_input_capture_meter_unit_tb.sv =====
module pwm_input_capture_meter_unit_tb;

    import picm_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_t             out_data;

    pwm_input_capture_meter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the meter state and its registers.
    logic [1:0]        meter_phase;
    logic [15:0]       start_cnt;
    logic [15:0]       ovf_cnt;
    logic [TICK_W-1:0] pend_high;
    logic [TICK_W-1:0] lat_high;
    logic [TICK_W-1:0] lat_period;
    logic              meas_valid;
    logic [CFG_W-1:0]  clock_hz;
    logic [CPO_W-1:0]  ticks_per_ovf;

    in_t  request_queue[$];
    out_t expected_readings[$];
    out_t wanted;

    int   errors = 0;
    int   requests_sent = 0;
    int   results_checked = 0;
    int   settings_used = 0;
    logic [15:0] last_cap = '0;

    logic tx_steady = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;

    logic        rx_steady = 1'b0;
    logic        rx_dense = 1'b1;
    logic [15:0] ready_pat = 16'hA5C3;
    int          pat_pos = 0;
    int          hold_left = 0;
    int          holds_asked = 0;
    int          holds_started = 0;

    function automatic void meter_clear();
        meter_phase   = PHASE_FIRST;
        start_cnt     = '0;
        ovf_cnt       = '0;
        pend_high     = '0;
        lat_high      = '0;
        lat_period    = '0;
        meas_valid    = 1'b0;
        clock_hz      = TIMER_CLOCK_HZ_RESET;
        ticks_per_ovf = COUNTS_PER_OVERFLOW_RESET;
    endfunction

    // Elapsed ticks since the start count, clamped to zero and to 32 bits.
    function automatic logic [TICK_W-1:0] elapsed_ticks(logic [15:0] cap);
        longint unsigned total;
        total = 64'(cap) + 64'(ovf_cnt) * 64'(ticks_per_ovf);
        if (total < 64'(start_cnt))
            return '0;
        total = total - 64'(start_cnt);
        if (total > 64'hFFFF_FFFF)
            return '1;
        return total[31:0];
    endfunction

    function automatic out_t predict_meter(in_t req);
        out_t            res;
        longint unsigned quot;
        if (req.mode == MODE_OVERFLOW)
        begin
            if (ovf_cnt != 16'hFFFF)
                ovf_cnt = ovf_cnt + 16'd1;
        end
        else if (meter_phase == PHASE_FALL)
        begin
            pend_high   = elapsed_ticks(req.capture_count);
            meter_phase = PHASE_RISE;
        end
        else if (meter_phase == PHASE_RISE)
        begin
            lat_period  = elapsed_ticks(req.capture_count);
            lat_high    = pend_high;
            meas_valid  = 1'b1;
            ovf_cnt     = '0;
            start_cnt   = req.capture_count;
            meter_phase = PHASE_FALL;
        end
        else
        begin
            start_cnt   = req.capture_count;
            ovf_cnt     = '0;
            meter_phase = PHASE_FALL;
        end
        res = '0;
        res.sense_falling = (meter_phase == PHASE_FALL) ? SENSE_FALL : SENSE_RISE;
        res.high_ticks    = lat_high;
        res.period_ticks  = lat_period;
        if (lat_period != '0)
        begin
            res.frequency_hz = clock_hz / lat_period;
            quot = (64'(lat_high) << 16) / 64'(lat_period);
            res.duty_fraction = (quot > 64'd65535) ? DUTY_MAX : quot[15:0];
        end
        res.measurement_valid = meas_valid;
        return res;
    endfunction

    function automatic void queue_request(logic m, logic [15:0] cap);
        in_t item;
        item.mode          = m;
        item.capture_count = cap;
        request_queue.push_back(item);
    endfunction

    // Mostly edges preceded by a few overflows, with some arbitrary requests mixed in.
    function automatic void queue_random_requests(int n);
        int          queued;
        int          k;
        logic [15:0] cap;
        queued = 0;
        while (queued < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                k = $urandom_range(3);
                repeat (k) queue_request(MODE_OVERFLOW, 16'($urandom));
                if ($urandom_range(1) == 1)
                    cap = 16'($urandom);
                else
                    cap = last_cap + 16'($urandom_range(300));
                queue_request(MODE_EDGE, cap);
                last_cap = cap;
                queued = queued + k + 1;
            end
            else
            begin
                queue_request(1'($urandom), 16'($urandom));
                queued = queued + 1;
            end
        end
    endfunction

    task automatic log_fault(input string msg);
        errors = errors + 1;
        if (errors <= 30)
            $display("ERROR: %s", msg);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_TIMER_CLOCK_HZ)
            clock_hz = val;
        else
            ticks_per_ovf = val[CPO_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_readings.push_back(predict_meter(in_data));
                requests_sent = requests_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() != 0 && (tx_steady || gap_left == 0))
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(12, 1);
                        if ($urandom_range(3) == 0)
                            gap_left <= $urandom_range(60, 10);
                        else
                            gap_left <= $urandom_range(8, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_started < holds_asked)
        begin
            out_ready     <= 1'b0;
            hold_left     <= 400;
            holds_started <= holds_started + 1;
        end
        else if (rx_steady)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= rx_dense ? (ready_pat[0] | ready_pat[1]) : ready_pat[0];
            if (pat_pos == 15)
            begin
                ready_pat <= 16'($urandom);
                pat_pos   <= 0;
            end
            else
            begin
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
                pat_pos   <= pat_pos + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
                log_fault("result arrived with no request outstanding");
            else
            begin
                wanted = expected_readings.pop_front();
                if (out_data.sense_falling !== wanted.sense_falling)
                    log_fault($sformatf("result %0d sense_falling got %0d want %0d",
                        results_checked, out_data.sense_falling, wanted.sense_falling));
                if (out_data.high_ticks !== wanted.high_ticks)
                    log_fault($sformatf("result %0d high_ticks got %0d want %0d",
                        results_checked, out_data.high_ticks, wanted.high_ticks));
                if (out_data.period_ticks !== wanted.period_ticks)
                    log_fault($sformatf("result %0d period_ticks got %0d want %0d",
                        results_checked, out_data.period_ticks, wanted.period_ticks));
                if (out_data.frequency_hz !== wanted.frequency_hz)
                    log_fault($sformatf("result %0d frequency_hz got %0d want %0d",
                        results_checked, out_data.frequency_hz, wanted.frequency_hz));
                if (out_data.duty_fraction !== wanted.duty_fraction)
                    log_fault($sformatf("result %0d duty_fraction got %0d want %0d",
                        results_checked, out_data.duty_fraction, wanted.duty_fraction));
                if (out_data.measurement_valid !== wanted.measurement_valid)
                    log_fault($sformatf("result %0d measurement_valid got %0d want %0d",
                        results_checked, out_data.measurement_valid,
                        wanted.measurement_valid));
                results_checked = results_checked + 1;
            end
        end
    end

    initial
    begin
        #64000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] hz_list[6];
        logic [CFG_W-1:0] cpo_list[6];
        meter_clear();
        hz_list  = '{32'd1, 32'($urandom), 32'd1000000, 32'hFFFF_FFFF,
                     32'($urandom), 32'd12345678};
        cpo_list = '{32'd1, 32'($urandom_range(65536, 1)), 32'd256, 32'd65536,
                     32'd1, 32'($urandom_range(65536, 1))};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: overflows ahead of the first edge, a high time longer
        // than the period, negative spans, zero periods and the capture extremes.
        settings_used = 1;
        queue_request(MODE_OVERFLOW, 16'hFFFF);
        queue_request(MODE_OVERFLOW, 16'h0000);
        queue_request(MODE_EDGE, 16'd1000);
        queue_request(MODE_OVERFLOW, 16'h1234);
        queue_request(MODE_EDGE, 16'd1500);
        queue_request(MODE_OVERFLOW, 16'h0000);
        queue_request(MODE_OVERFLOW, 16'h0000);
        queue_request(MODE_EDGE, 16'd900);
        queue_request(MODE_EDGE, 16'hFFFF);
        queue_request(MODE_OVERFLOW, 16'h0000);
        queue_request(MODE_EDGE, 16'h0000);
        queue_request(MODE_EDGE, 16'h0000);
        queue_request(MODE_OVERFLOW, 16'h0000);
        queue_request(MODE_EDGE, 16'hFFFF);
        queue_request(MODE_EDGE, 16'h5555);
        queue_request(MODE_OVERFLOW, 16'hAAAA);
        queue_request(MODE_OVERFLOW, 16'h5555);
        queue_request(MODE_EDGE, 16'hAAAA);
        queue_request(MODE_EDGE, 16'h0000);
        queue_request(MODE_EDGE, 16'h0000);
        queue_request(MODE_EDGE, 16'h0000);
        queue_request(MODE_EDGE, 16'h0000);
        wait_idle();

        // The period is zero here, so each request is short. A long run of
        // overflows inside one high phase gives large tick counts.
        write_reg(REG_COUNTS_PER_OVERFLOW, 32'd65536);
        write_reg(REG_TIMER_CLOCK_HZ, 32'hFFFF_FFFF);
        settings_used = settings_used + 1;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (200) queue_request(MODE_OVERFLOW, 16'($urandom));
        queue_request(MODE_EDGE, 16'hFFFF);
        queue_request(MODE_EDGE, 16'hFFFF);
        queue_request(MODE_OVERFLOW, 16'h0000);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_TIMER_CLOCK_HZ, hz_list[p]);
            write_reg(REG_COUNTS_PER_OVERFLOW, cpo_list[p]);
            settings_used = settings_used + 1;
            tx_steady = (p == 2) || (p == 3);
            rx_steady = (p == 2);
            rx_dense  = (p % 2 == 0);
            queue_random_requests(160);
            if (p == 3)
                holds_asked = holds_asked + 1;
            wait_idle();
        end

        repeat (100) @(posedge clk);
        $display("Checked %0d results from %0d requests across %0d register settings.",
            results_checked, requests_sent, settings_used);
        $display("Included long overflow runs, zero and negative spans, and a long output stall.");
        if (errors == 0 && expected_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== pwm_input_capture_meter_unit.f =====
rtl/picm_pkg.sv
rtl/picm_div.sv
rtl/picm_dp.sv
rtl/picm_ctrl.sv
rtl/pwm_input_capture_meter_unit.sv
test/pwm_input_capture_meter_unit_tb.sv
